### rtl/nstp_pkg.sv
package nstp_pkg;

	localparam int CNT_W = 32;
	localparam int TIME_W = 64;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// event codes; the fourth code behaves as a read
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_END = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [TIME_W-1:0] timestamp;
	} evt_t;

	typedef struct packed {
		logic [CNT_W-1:0] scopes_started;
		logic [CNT_W-1:0] scopes_nested;
		logic [CNT_W-1:0] scopes_completed;
		logic [CNT_W-1:0] scopes_timed;
		logic [CNT_W-1:0] sequence_errors;
		logic [CNT_W-1:0] clock_errors;
		logic [CNT_W-1:0] open_depth;
		logic [TIME_W-1:0] time_sum;
		logic [TIME_W-1:0] time_max;
		logic saturated;
		logic tracking_lost;
	} snap_t;

endpackage

### rtl/nested_scope_time_profiler_core.sv
// Nested scope time profiler. Each event transaction (begin, end or read, with a
// 64-bit timestamp in microseconds) returns exactly one snapshot transaction holding
// all counters after the event is applied. The block takes one event per clock cycle
// while snap_ready does not hold it back. A snapshot is presented once its event has
// passed the input register and then the result register. The counter update for one
// event is combinational between those registers. When snap_ready stays low the block
// holds up to two events and then drops evt_ready. Outermost begin latches the start
// time, outermost end adds the elapsed time to a saturating sum and tracks the maximum,
// unless its timestamp is below the start time, which counts a clock error instead.
// Counters saturate and set the sticky saturated flag; a depth overflow stops scope
// tracking until reset, while reads keep working.
module nested_scope_time_profiler_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	output logic             evt_ready,
	input  nstp_pkg::evt_t   evt,
	output logic             snap_valid,
	input  logic             snap_ready,
	output nstp_pkg::snap_t  snap
);

	localparam int CW = nstp_pkg::CNT_W;
	localparam int TW = nstp_pkg::TIME_W;

	// saturating increment: {hit limit, next value}
	function automatic logic [CW:0] sat_inc(input logic [CW-1:0] c);
		if (c == nstp_pkg::CNT_MAX) begin
			return {1'b1, c};
		end
		return {1'b0, c + 1'b1};
	endfunction

	// input stage
	logic             valid_s1;
	nstp_pkg::evt_t   evt_s1;
	logic             advance;

	// profiler state
	logic [CW-1:0] started_q, nested_q, completed_q, timed_q, bad_seq_q, bad_clk_q, depth_q;
	logic [TW-1:0] start_q, sum_q, peak_q;
	logic          sat_q, lost_q;

	logic [CW-1:0] started_d, nested_d, completed_d, timed_d, bad_seq_d, bad_clk_d, depth_d;
	logic [TW-1:0] start_d, sum_d, peak_d;
	logic          sat_d, lost_d;

	logic [CW:0]   inc_started, inc_nested, inc_completed, inc_timed, inc_bad_seq, inc_bad_clk;
	logic [TW-1:0] span;
	logic [TW:0]   sum_wide;
	logic          clk_err;

	// result register
	logic            snap_valid_q;
	nstp_pkg::snap_t snap_q;

	assign advance = valid_s1 && (!snap_valid_q || snap_ready);
	assign evt_ready = !valid_s1 || advance;

	// hold the accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			evt_s1 <= evt;
		end
	end

	// candidate increments and timing arithmetic
	assign inc_started = sat_inc(started_q);
	assign inc_nested = sat_inc(nested_q);
	assign inc_completed = sat_inc(completed_q);
	assign inc_timed = sat_inc(timed_q);
	assign inc_bad_seq = sat_inc(bad_seq_q);
	assign inc_bad_clk = sat_inc(bad_clk_q);
	assign clk_err = evt_s1.timestamp < start_q;
	assign span = evt_s1.timestamp - start_q;
	assign sum_wide = {1'b0, sum_q} + {1'b0, span};

	// apply the event to the state
	always_comb begin
		started_d = started_q;
		nested_d = nested_q;
		completed_d = completed_q;
		timed_d = timed_q;
		bad_seq_d = bad_seq_q;
		bad_clk_d = bad_clk_q;
		depth_d = depth_q;
		start_d = start_q;
		sum_d = sum_q;
		peak_d = peak_q;
		sat_d = sat_q;
		lost_d = lost_q;
		if (!lost_q) begin
			case (evt_s1.op)
				nstp_pkg::OP_BEGIN: begin
					if (depth_q != '0) begin
						nested_d = inc_nested[CW-1:0];
						sat_d = sat_d | inc_nested[CW];
						if (depth_q == nstp_pkg::CNT_MAX) begin
							sat_d = 1'b1;
							bad_seq_d = inc_bad_seq[CW-1:0];
							lost_d = 1'b1;
						end else begin
							depth_d = depth_q + 1'b1;
						end
					end else begin
						started_d = inc_started[CW-1:0];
						sat_d = sat_d | inc_started[CW];
						depth_d = CW'(1);
						start_d = evt_s1.timestamp;
					end
				end
				nstp_pkg::OP_END: begin
					if (depth_q == '0) begin
						bad_seq_d = inc_bad_seq[CW-1:0];
						sat_d = sat_d | inc_bad_seq[CW];
					end else begin
						depth_d = depth_q - 1'b1;
						if (depth_q == CW'(1)) begin
							completed_d = inc_completed[CW-1:0];
							sat_d = sat_d | inc_completed[CW];
							if (clk_err) begin
								bad_clk_d = inc_bad_clk[CW-1:0];
								sat_d = sat_d | inc_bad_clk[CW];
							end else begin
								timed_d = inc_timed[CW-1:0];
								sat_d = sat_d | inc_timed[CW];
								if (sum_wide[TW]) begin
									sum_d = nstp_pkg::TIME_MAX;
									sat_d = 1'b1;
								end else begin
									sum_d = sum_wide[TW-1:0];
								end
								if (span > peak_q) begin
									peak_d = span;
								end
							end
						end
					end
				end
				default: begin
					// read only: state holds
				end
			endcase
		end
	end

	// advance the state once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
			nested_q <= '0;
			completed_q <= '0;
			timed_q <= '0;
			bad_seq_q <= '0;
			bad_clk_q <= '0;
			depth_q <= '0;
			start_q <= '0;
			sum_q <= '0;
			peak_q <= '0;
			sat_q <= 1'b0;
			lost_q <= 1'b0;
		end else if (advance) begin
			started_q <= started_d;
			nested_q <= nested_d;
			completed_q <= completed_d;
			timed_q <= timed_d;
			bad_seq_q <= bad_seq_d;
			bad_clk_q <= bad_clk_d;
			depth_q <= depth_d;
			start_q <= start_d;
			sum_q <= sum_d;
			peak_q <= peak_d;
			sat_q <= sat_d;
			lost_q <= lost_d;
		end
	end

	// drive the result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
		end else if (advance) begin
			snap_valid_q <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			snap_q.scopes_started <= started_d;
			snap_q.scopes_nested <= nested_d;
			snap_q.scopes_completed <= completed_d;
			snap_q.scopes_timed <= timed_d;
			snap_q.sequence_errors <= bad_seq_d;
			snap_q.clock_errors <= bad_clk_d;
			snap_q.open_depth <= depth_d;
			snap_q.time_sum <= sum_d;
			snap_q.time_max <= peak_d;
			snap_q.saturated <= sat_d;
			snap_q.tracking_lost <= lost_d;
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap = snap_q;

endmodule

### test/nested_scope_time_profiler_core_tb.sv
`timescale 1ns / 100ps

module nested_scope_time_profiler_core_tb;

	localparam int CW = nstp_pkg::CNT_W;
	localparam int TW = nstp_pkg::TIME_W;

	// the unused fourth event code; the block treats it as a read
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;

	// running profile state and the snapshots still owed by the block
	class profile_tracker;
		logic [CW-1:0] started, nested, completed, timed, bad_seq, bad_clk, depth;
		logic [TW-1:0] t_open, t_sum, t_peak;
		logic sat, lost;
		nstp_pkg::snap_t snaps_due[$];
		int mismatches;
		int checked;

		function new();
			started = '0;
			nested = '0;
			completed = '0;
			timed = '0;
			bad_seq = '0;
			bad_clk = '0;
			depth = '0;
			t_open = '0;
			t_sum = '0;
			t_peak = '0;
			sat = 1'b0;
			lost = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function int pending();
			return snaps_due.size();
		endfunction

		// hold a counter at its top value and flag it
		function logic [CW-1:0] bump(logic [CW-1:0] c);
			if (c == nstp_pkg::CNT_MAX) begin
				sat = 1'b1;
				return c;
			end
			return c + 1'b1;
		endfunction

		// apply one accepted event and queue the snapshot it produces
		function void take_event(nstp_pkg::evt_t e);
			logic [TW-1:0] span;
			nstp_pkg::snap_t s;
			if (e.op == nstp_pkg::OP_BEGIN && !lost) begin
				if (depth != '0) begin
					nested = bump(nested);
					if (depth == nstp_pkg::CNT_MAX) begin
						sat = 1'b1;
						bad_seq = bump(bad_seq);
						lost = 1'b1;
					end else begin
						depth = depth + 1'b1;
					end
				end else begin
					started = bump(started);
					depth = CW'(1);
					t_open = e.timestamp;
				end
			end else if (e.op == nstp_pkg::OP_END && !lost) begin
				if (depth == '0) begin
					bad_seq = bump(bad_seq);
				end else begin
					depth = depth - 1'b1;
					if (depth == '0) begin
						completed = bump(completed);
						if (e.timestamp < t_open) begin
							bad_clk = bump(bad_clk);
						end else begin
							span = e.timestamp - t_open;
							timed = bump(timed);
							if (nstp_pkg::TIME_MAX - t_sum < span) begin
								t_sum = nstp_pkg::TIME_MAX;
								sat = 1'b1;
							end else begin
								t_sum = t_sum + span;
							end
							if (span > t_peak)
								t_peak = span;
						end
					end
				end
			end
			s.scopes_started = started;
			s.scopes_nested = nested;
			s.scopes_completed = completed;
			s.scopes_timed = timed;
			s.sequence_errors = bad_seq;
			s.clock_errors = bad_clk;
			s.open_depth = depth;
			s.time_sum = t_sum;
			s.time_max = t_peak;
			s.saturated = sat;
			s.tracking_lost = lost;
			snaps_due.push_back(s);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("snapshot %0d %s: expected %0h, got %0h",
						checked, name, want, got);
			end
		endfunction

		// match one snapshot transaction against the oldest expectation
		function void check_snapshot(nstp_pkg::snap_t got);
			nstp_pkg::snap_t want;
			if (snaps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("snapshot %0d arrived with none expected: %0h", checked, got);
				return;
			end
			want = snaps_due.pop_front();
			compare_field("scopes_started", 64'(want.scopes_started),
				64'(got.scopes_started));
			compare_field("scopes_nested", 64'(want.scopes_nested),
				64'(got.scopes_nested));
			compare_field("scopes_completed", 64'(want.scopes_completed),
				64'(got.scopes_completed));
			compare_field("scopes_timed", 64'(want.scopes_timed),
				64'(got.scopes_timed));
			compare_field("sequence_errors", 64'(want.sequence_errors),
				64'(got.sequence_errors));
			compare_field("clock_errors", 64'(want.clock_errors),
				64'(got.clock_errors));
			compare_field("open_depth", 64'(want.open_depth), 64'(got.open_depth));
			compare_field("time_sum", want.time_sum, got.time_sum);
			compare_field("time_max", want.time_max, got.time_max);
			compare_field("saturated", 64'(want.saturated), 64'(got.saturated));
			compare_field("tracking_lost", 64'(want.tracking_lost),
				64'(got.tracking_lost));
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic evt_valid;
	logic evt_ready;
	nstp_pkg::evt_t evt;
	logic snap_valid;
	logic snap_ready;
	nstp_pkg::snap_t snap;

	profile_tracker book;
	int sent = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	logic [TW-1:0] tick_now = 64'd1000;

	nested_scope_time_profiler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap(snap)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nested_scope_time_profiler_core: mismatch");
			$finish;
		end
	end

	// check every snapshot transaction
	always @(posedge clk) begin
		if (arst_n && snap_valid && snap_ready)
			book.check_snapshot(snap);
	end

	// drop snap_ready in random bursts, or for a long hold when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end else if (hold_left == 0 && $urandom_range(99) < rx_idle_pct) begin
				hold_left = $urandom_range(1, 17);
			end
			if (hold_left > 0) begin
				snap_ready <= 1'b0;
				hold_left--;
			end else begin
				snap_ready <= 1'b1;
			end
		end
	end

	function automatic logic [TW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// offer one event transaction, after an optional idle burst
	task automatic offer(input logic [1:0] op, input logic [TW-1:0] ts);
		nstp_pkg::evt_t e;
		int gap;
		e.op = op;
		e.timestamp = ts;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		do @(posedge clk); while (!evt_ready);
		book.take_event(e);
		sent++;
	endtask

	// stop offering and wait until every snapshot is back
	task automatic drain();
		@(negedge clk);
		evt_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// one outermost scope with random nesting, reads and ignored timestamps inside
	task automatic run_scope();
		logic [TW-1:0] base, fin;
		int lvl;
		int steps;
		lvl = 1;
		if ($urandom_range(3) == 0) begin
			base = rand64();
		end else begin
			base = tick_now;
			tick_now = tick_now + $urandom_range(1, 200);
		end
		offer(nstp_pkg::OP_BEGIN, base);
		steps = $urandom_range(0, 8);
		repeat (steps) begin
			case ($urandom_range(3))
				0: if (lvl < 6) begin
					offer(nstp_pkg::OP_BEGIN, rand64());
					lvl++;
				end
				1: if (lvl > 1) begin
					offer(nstp_pkg::OP_END, rand64());
					lvl--;
				end
				2: offer(nstp_pkg::OP_READ, rand64());
				default: offer(OP_SPARE, rand64());
			endcase
		end
		while (lvl > 1) begin
			offer(nstp_pkg::OP_END, rand64());
			lvl--;
		end
		// mostly a forward span, sometimes zero, sometimes a clock going back
		case ($urandom_range(15))
			0: fin = (base > 64'd1000) ? base - $urandom_range(1, 1000) : base;
			1: fin = base;
			default: fin = base + $urandom_range(1, 5000);
		endcase
		offer(nstp_pkg::OP_END, fin);
	endtask

	// well-formed scopes with some stray and random events mixed in
	task automatic random_traffic(input int upto);
		while (sent < upto) begin
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(2))
					0: offer(nstp_pkg::OP_END, rand64());
					1: offer(2'($urandom_range(3)), rand64());
					default: offer(OP_SPARE, rand64());
				endcase
			end else begin
				run_scope();
			end
		end
	endtask

	initial begin
		book = new();
		arst_n = 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		snap_ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every op, error cases
		tx_idle_pct = 20;
		rx_idle_pct = 6;
		offer(nstp_pkg::OP_READ, '0);
		offer(OP_SPARE, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_END, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_BEGIN, '0);
		offer(nstp_pkg::OP_BEGIN, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_READ, 64'h5555_5555_5555_5555);
		offer(nstp_pkg::OP_END, 64'd5);
		offer(nstp_pkg::OP_END, 64'd100);
		offer(nstp_pkg::OP_BEGIN, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_END, '0);
		offer(nstp_pkg::OP_BEGIN, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_END, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_BEGIN, 64'hAAAA_AAAA_AAAA_AAAA);
		offer(OP_SPARE, 64'h5555_5555_5555_5555);
		offer(nstp_pkg::OP_END, 64'hAAAA_AAAA_AAAA_AAB1);
		offer(nstp_pkg::OP_BEGIN, 64'h5555_5555_5555_5555);
		offer(nstp_pkg::OP_END, 64'h5555_5555_5555_5558);
		offer(nstp_pkg::OP_END, '0);
		drain();

		// random traffic with idling on both sides
		tx_idle_pct = 15;
		rx_idle_pct = 6;
		random_traffic(600);

		// long receiver hold while events keep coming
		tx_idle_pct = 0;
		hold_req = 80;
		random_traffic(660);
		drain();

		// a stretch with no idling
		rx_idle_pct = 0;
		random_traffic(860);

		tx_idle_pct = 25;
		rx_idle_pct = 10;
		random_traffic(1500);

		// tail without idling, then fill the sum exactly and overflow it
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_traffic(1680);
		while (book.depth != '0)
			offer(nstp_pkg::OP_END, rand64());
		offer(nstp_pkg::OP_BEGIN, '0);
		offer(nstp_pkg::OP_END, nstp_pkg::TIME_MAX - book.t_sum);
		offer(nstp_pkg::OP_READ, '0);
		offer(nstp_pkg::OP_BEGIN, 64'd10);
		offer(nstp_pkg::OP_END, 64'd11);
		offer(nstp_pkg::OP_BEGIN, '0);
		offer(nstp_pkg::OP_END, nstp_pkg::TIME_MAX);
		offer(nstp_pkg::OP_END, 64'd7);
		offer(nstp_pkg::OP_READ, nstp_pkg::TIME_MAX);

		drain();
		repeat (10) @(posedge clk);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("nested_scope_time_profiler_core: match");
		else
			$display("nested_scope_time_profiler_core: mismatch");
		$finish;
	end

endmodule
